FILE: rtl/pgccs_pkg.sv
// ----------------------------------------------------------------------------
// PMT group coincidence charge sum package
// Shared widths, constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package pgccs_pkg;

  localparam int Channels   = 4;
  localparam int PulseW     = 16;
  localparam int AreaW      = 15;
  localparam int PosW       = 10;
  localparam int PeFracBits = 8;
  localparam int OnePeArea  = 23;

  // floor(area * 2^8 / 23) is taken as (area * ceil(2^28 / 23)) >> 20, exact
  // for every 15-bit area.
  localparam int RecipExp   = 28;
  localparam int RecipShift = RecipExp - PeFracBits;
  localparam int RecipW     = 24;
  localparam logic [RecipW-1:0] PeRecip =
    RecipW'(((2 ** RecipExp) + OnePeArea - 1) / OnePeArea);
  localparam int ProdW      = AreaW + RecipW;
  localparam int PeW        = 19;

  localparam int IdxW       = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int CntW       = $clog2(Channels + 1);
  localparam int SumAreaW   = AreaW + $clog2(Channels);
  localparam int SumPeW     = PeW + $clog2(Channels);

  localparam int ChargeW    = 17;
  localparam int TotalPeW   = 21;
  localparam int CoinW      = 3;
  localparam int EventW     = 16;

  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 15;
  localparam int PosThrW    = 10;

  localparam logic [PosThrW-1:0] PosThrReset  = PosThrW'(40);
  localparam logic [AreaW-1:0]   AreaThrReset = AreaW'(0);
  localparam logic [PosW-1:0]    WinMinReset  = PosW'(19);
  localparam logic [PosW-1:0]    WinMaxReset  = PosW'(80);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPosThr  = 2'd0,
    CfgAreaThr = 2'd1,
    CfgWinMin  = 2'd2,
    CfgWinMax  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PulseW-1:0] pulse_a;
    logic signed [PulseW-1:0] pulse_b;
    logic signed [PulseW-1:0] pulse_c;
    logic signed [PulseW-1:0] pulse_d;
    logic [PosW-1:0]          peak_pos_a;
    logic [PosW-1:0]          peak_pos_b;
    logic [PosW-1:0]          peak_pos_c;
    logic [PosW-1:0]          peak_pos_d;
    logic                     detector_id;
    logic [EventW-1:0]        event_number;
  } in_t;

  typedef struct packed {
    logic [ChargeW-1:0]  total_charge;
    logic [TotalPeW-1:0] total_pe;
    logic [CoinW-1:0]    coincidences;
    logic                detector_out;
    logic [EventW-1:0]   event_out;
  } out_t;

  // Area threshold and window settings seen by every lane.
  typedef struct packed {
    logic [AreaW-1:0] area_thr;
    logic [PosW-1:0]  win_min;
    logic [PosW-1:0]  win_max;
  } lane_cfg_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [AreaW-1:0] area;
    logic [PeW-1:0]   pe;
    logic [PosW-1:0]  pos;
  } lane_t;

  typedef struct packed {
    logic              detector_id;
    logic [EventW-1:0] event_number;
  } tag_t;

endpackage

FILE: rtl/pgccs_lane.sv
// ----------------------------------------------------------------------------
// PMT group lane
// Accepts or rejects one channel and converts its area to photoelectrons.
// ----------------------------------------------------------------------------
module pgccs_lane import pgccs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [PulseW-1:0] pulse_i,
  input  logic [PosW-1:0]          pos_i,
  input  lane_cfg_t                cfg_i,
  output lane_t                    lane_o
);

  logic              accept;
  logic [AreaW-1:0]  area_raw;
  logic [ProdW-1:0]  prod;
  lane_t             lane_d, lane_q;

  // A negative area can never reach the non-negative threshold.
  assign area_raw = pulse_i[AreaW-1:0];
  assign accept   = !pulse_i[PulseW-1] && (area_raw >= cfg_i.area_thr) &&
                    (pos_i > cfg_i.win_min) && (pos_i <= cfg_i.win_max);
  assign prod     = ProdW'(area_raw) * ProdW'(PeRecip);

  always_comb begin
    lane_d.pos  = pos_i;
    lane_d.area = accept ? area_raw : '0;
    lane_d.pe   = accept ? prod[RecipShift +: PeW] : '0;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

FILE: rtl/pgccs_merge.sv
// ----------------------------------------------------------------------------
// PMT group merge
// Finds the strongest lane, applies the position cut and sums the survivors.
// ----------------------------------------------------------------------------
module pgccs_merge import pgccs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lane_t              lane_i [Channels],
  input  tag_t               tag_i,
  input  logic [PosThrW-1:0] pos_thr_i,
  output logic               valid_o,
  output out_t               result_o
);

  // Stage A: strongest lane and nonzero count.
  logic            a_valid_q;
  lane_t           a_lane_q [Channels];
  tag_t            a_tag_q;
  logic [IdxW-1:0] a_best_d, a_best_q;
  logic [CntW-1:0] a_cnt_d, a_cnt_q;

  always_comb begin
    a_best_d = '0;
    a_cnt_d  = '0;
    for (int k = 0; k < Channels; k++) begin
      if (lane_i[k].area > lane_i[a_best_d].area) begin
        a_best_d = IdxW'(k);
      end
      a_cnt_d = a_cnt_d + CntW'(lane_i[k].area != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_lane_q <= lane_i;
    a_tag_q  <= tag_i;
    a_best_q <= a_best_d;
    a_cnt_q  <= a_cnt_d;
  end

  // Stage B: position cut around the strongest lane when at least two lanes carry charge, then the sums.
  logic                b_valid_q;
  logic [PosW-1:0]     best_pos;
  logic [SumAreaW-1:0] charge_sum;
  logic [SumPeW-1:0]   pe_sum;
  out_t                res_d, res_q;

  assign best_pos = a_lane_q[a_best_q].pos;

  always_comb begin
    logic [PosW-1:0] diff;
    logic            keep;
    charge_sum = '0;
    pe_sum     = '0;
    for (int k = 0; k < Channels; k++) begin
      diff = (a_lane_q[k].pos > best_pos) ? a_lane_q[k].pos - best_pos
                                          : best_pos - a_lane_q[k].pos;
      keep = (a_cnt_q < CntW'(2)) || (PosThrW'(diff) <= pos_thr_i);
      if (keep) begin
        charge_sum = charge_sum + SumAreaW'(a_lane_q[k].area);
        pe_sum     = pe_sum + SumPeW'(a_lane_q[k].pe);
      end
    end
    res_d.total_charge = ChargeW'(charge_sum);
    res_d.total_pe     = TotalPeW'(pe_sum);
    res_d.coincidences = CoinW'(a_cnt_q);
    res_d.detector_out = a_tag_q.detector_id;
    res_d.event_out    = a_tag_q.event_number;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = b_valid_q;
  assign result_o = res_q;

  // The chosen lane carries charge whenever any lane does.
  a_best_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && (a_cnt_q != '0) |-> (a_lane_q[a_best_q].area != '0))
    else $error("strongest lane has zero area");

  // An empty group sums to nothing.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && (res_q.coincidences == '0) |->
      (res_q.total_charge == '0) && (res_q.total_pe == '0))
    else $error("nonzero sums for a group without coincidences");

  // Each stage A item becomes exactly one result on the next cycle.
  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |=> b_valid_q)
    else $error("result lost between merge stages");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |=> !b_valid_q)
    else $error("result strobe without an item");

endmodule

FILE: rtl/pmt_group_coincidence_charge_sum_core.sv
// ----------------------------------------------------------------------------
// PMT group coincidence charge sum core
// Qualifies four channels of one detector group in parallel lanes, counts
// coincidences, cuts channels far from the strongest one and sums charge and
// photoelectrons.
//
//   Channel   Signals                                   Transfer
//   input     start_i, busy_o, item_i                   start_i && !busy_o
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,    cfg_valid_i && cfg_ready_o
//             cfg_data_i
//   result    done_o, result_o                          done_o (one cycle)
//
// A new group is taken every cycle; busy_o stays low.
// Each result passes through the lane register, the strongest channel search
// register, then the position cut and summation register.
// Reset clears the pipeline strobes and loads the register defaults.
// The receiver cannot stall, so no backpressure exists anywhere.
// ----------------------------------------------------------------------------
module pmt_group_coincidence_charge_sum_core import pgccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  in_t                 item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output out_t                result_o
);

  logic [PosThrW-1:0] pos_thr_q;
  logic [AreaW-1:0]   area_thr_q;
  logic [PosW-1:0]    win_min_q, win_max_q;
  lane_cfg_t          lane_cfg;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_thr_q  <= PosThrReset;
      area_thr_q <= AreaThrReset;
      win_min_q  <= WinMinReset;
      win_max_q  <= WinMaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgPosThr:  pos_thr_q  <= cfg_data_i[PosThrW-1:0];
        CfgAreaThr: area_thr_q <= cfg_data_i[AreaW-1:0];
        CfgWinMin:  win_min_q  <= cfg_data_i[PosW-1:0];
        CfgWinMax:  win_max_q  <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.area_thr = area_thr_q;
  assign lane_cfg.win_min  = win_min_q;
  assign lane_cfg.win_max  = win_max_q;

  logic signed [PulseW-1:0] pulse [Channels];
  logic [PosW-1:0]          pos   [Channels];
  lane_t                    lane  [Channels];

  assign pulse[0] = item_i.pulse_a;
  assign pulse[1] = item_i.pulse_b;
  assign pulse[2] = item_i.pulse_c;
  assign pulse[3] = item_i.pulse_d;
  assign pos[0]   = item_i.peak_pos_a;
  assign pos[1]   = item_i.peak_pos_b;
  assign pos[2]   = item_i.peak_pos_c;
  assign pos[3]   = item_i.peak_pos_d;

  for (genvar g = 0; g < Channels; g++) begin : g_lane
    pgccs_lane u_lane (
      .clk_i   (clk_i),
      .pulse_i (pulse[g]),
      .pos_i   (pos[g]),
      .cfg_i   (lane_cfg),
      .lane_o  (lane[g])
    );
  end

  logic valid_q;
  tag_t tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q.detector_id  <= item_i.detector_id;
    tag_q.event_number <= item_i.event_number;
  end

  pgccs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_q),
    .lane_i    (lane),
    .tag_i     (tag_q),
    .pos_thr_i (pos_thr_q),
    .valid_o   (done_o),
    .result_o  (result_o)
  );

endmodule

FILE: tb/pmt_group_coincidence_charge_sum_core_test.sv
// ----------------------------------------------------------------------------
// PMT group coincidence charge sum core testbench
// Drives detector groups in random bursts through several register settings,
// predicts each coincidence count and charge and photoelectron sum, and
// compares every result field with the oldest pending prediction.
// ----------------------------------------------------------------------------
import pgccs_pkg::*;

class charge_sum_board;
  logic [PosThrW-1:0] pos_thr  = PosThrReset;
  logic [AreaW-1:0]   area_thr = AreaThrReset;
  logic [PosW-1:0]    win_min  = WinMinReset;
  logic [PosW-1:0]    win_max  = WinMaxReset;
  out_t               sums[$];
  int unsigned        errors;

  function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgPosThr:  pos_thr  = data[PosThrW-1:0];
      CfgAreaThr: area_thr = data[AreaW-1:0];
      CfgWinMin:  win_min  = data[PosW-1:0];
      CfgWinMax:  win_max  = data[PosW-1:0];
      default: ;
    endcase
  endfunction

  // Works out the sums of one accepted group and queues them.
  function void note_group(in_t g);
    int   pulse [Channels];
    int   pos [Channels];
    int   area [Channels];
    int   pe [Channels];
    int   live;
    int   best;
    int   charge;
    int   pesum;
    int   d;
    out_t r;
    pulse = '{$signed(g.pulse_a), $signed(g.pulse_b), $signed(g.pulse_c),
              $signed(g.pulse_d)};
    pos = '{g.peak_pos_a, g.peak_pos_b, g.peak_pos_c, g.peak_pos_d};
    live = 0;
    best = 0;
    charge = 0;
    pesum = 0;
    for (int k = 0; k < Channels; k++) begin
      if (pulse[k] >= int'(area_thr) && pos[k] > int'(win_min) &&
          pos[k] <= int'(win_max)) begin
        area[k] = pulse[k];
        pe[k] = (pulse[k] * (1 << PeFracBits)) / OnePeArea;
      end else begin
        area[k] = 0;
        pe[k] = 0;
      end
      if (area[k] != 0) live++;
      if (area[k] > area[best]) best = k;
    end
    // The position cut only applies once there is a real coincidence.
    if (live >= 2) begin
      for (int k = 0; k < Channels; k++) begin
        d = pos[k] - pos[best];
        if (d < 0) d = -d;
        if (d > int'(pos_thr)) begin
          area[k] = 0;
          pe[k] = 0;
        end
      end
    end
    for (int k = 0; k < Channels; k++) begin
      charge += area[k];
      pesum += pe[k];
    end
    r.total_charge = ChargeW'(charge);
    r.total_pe     = TotalPeW'(pesum);
    r.coincidences = CoinW'(live);
    r.detector_out = g.detector_id;
    r.event_out    = g.event_number;
    sums = {sums, r};
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_sum(out_t got);
    out_t want;
    if (sums.size() == 0) begin
      errors++;
      $display("%0t: result with no group pending: expected none, got %p", $time, got);
      return;
    end
    want = sums.pop_front();
    compare("total_charge", want.total_charge, got.total_charge);
    compare("total_pe", want.total_pe, got.total_pe);
    compare("coincidences", want.coincidences, got.coincidences);
    compare("detector_out", want.detector_out, got.detector_out);
    compare("event_out", want.event_out, got.event_out);
  endfunction
endclass

module pmt_group_coincidence_charge_sum_core_test;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  in_t                 item_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                done_o;
  out_t                result_o;

  charge_sum_board sb;

  pmt_group_coincidence_charge_sum_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_sum(result_o);
  end

  function automatic in_t make_group(input int a0, a1, a2, a3, p0, p1, p2, p3,
                                     input bit det, input int ev);
    in_t g;
    g.pulse_a = PulseW'(a0);
    g.pulse_b = PulseW'(a1);
    g.pulse_c = PulseW'(a2);
    g.pulse_d = PulseW'(a3);
    g.peak_pos_a = PosW'(p0);
    g.peak_pos_b = PosW'(p1);
    g.peak_pos_c = PosW'(p2);
    g.peak_pos_d = PosW'(p3);
    g.detector_id = det;
    g.event_number = EventW'(ev);
    return g;
  endfunction

  // Mostly channels that pass the cuts and sit near a common position, so the
  // strongest channel search and the position cut are exercised; the rest is
  // noise, zero areas, negative areas and values right at the thresholds.
  function automatic in_t random_group();
    int pulse [Channels];
    int pos [Channels];
    int lo;
    int hi;
    int span;
    int base;
    lo = int'(sb.win_min) + 1;
    hi = int'(sb.win_max);
    span = int'(sb.pos_thr) + 2;
    base = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(1023, 0);
    for (int k = 0; k < Channels; k++) begin
      pos[k] = base + $urandom_range(2 * span, 0) - span;
      if ($urandom_range(7, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: pos[k] = lo - 1;
          1: pos[k] = lo;
          2: pos[k] = hi;
          default: pos[k] = hi + 1;
        endcase
      end
      case ($urandom_range(9, 0))
        0: begin
          pulse[k] = $signed(PulseW'($urandom));
          pos[k] = $urandom_range(1023, 0);
        end
        1: pulse[k] = 0;
        2: pulse[k] = -int'($urandom_range(32768, 1));
        3: pulse[k] = int'(sb.area_thr);
        4: pulse[k] = int'(sb.area_thr) - 1;
        default: pulse[k] = $urandom_range(32767, int'(sb.area_thr));
      endcase
      if (pos[k] < 0) pos[k] = 0;
      if (pos[k] > 1023) pos[k] = 1023;
    end
    if ($urandom_range(5, 0) == 0) pulse[$urandom_range(Channels - 1, 1)] = pulse[0];
    return make_group(pulse[0], pulse[1], pulse[2], pulse[3],
                      pos[0], pos[1], pos[2], pos[3], 1'($urandom), $urandom);
  endfunction

  task automatic send_group(input in_t g);
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i <= g;
    do @(posedge clk_i); while (busy_o);
    sb.note_group(g);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      item_i <= in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'(value);
    // The position registers are narrower than the data bus; the upper bits
    // carry noise that must be dropped.
    if (idx != CfgAreaThr) data[CfgDataW-1:PosW] = (CfgDataW - PosW)'($urandom);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    int n;
    n = 0;
    while (sb.sums.size() != 0 && n < 500) begin
      @(posedge clk_i);
      n++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input int pos_thr, area_thr, win_min, win_max);
    idle_cycles(1);
    drain_results();
    write_reg(CfgPosThr, pos_thr);
    write_reg(CfgAreaThr, area_thr);
    write_reg(CfgWinMin, win_min);
    write_reg(CfgWinMax, win_max);
  endtask

  task automatic random_groups(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      if (burst > left) burst = left;
      repeat (burst) send_group(random_group());
      left -= burst;
      if ($urandom_range(3, 0) != 0) idle_cycles($urandom_range(6, 1));
    end
  endtask

  initial begin
    sb = new;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: window 19 < pos <= 80, distance limit 40.
    send_group(make_group(0, 0, 0, 0, 50, 50, 50, 50, 0, 0));
    send_group(make_group(32767, 32767, 32767, 32767, 50, 50, 50, 50, 1, 65535));
    send_group(make_group(-32768, -32768, -32768, -32768, 50, 50, 50, 50, 0, 1));
    send_group(make_group(100, 200, 300, 400, 19, 20, 80, 81, 1, 2));
    send_group(make_group(0, 500, 0, 0, 50, 60, 50, 50, 0, 3));
    send_group(make_group(700, 0, 0, 0, 30, 0, 1023, 512, 1, 4));
    send_group(make_group(100, 50, 100, 0, 21, 60, 80, 50, 0, 5));
    send_group(make_group(100, 50, 100, 0, 80, 60, 21, 50, 1, 6));
    send_group(make_group(1000, 900, 800, 0, 30, 70, 71, 50, 0, 7));
    send_group(make_group(5, 5, 5, 5, 0, 1023, 0, 1023, 1, 8));
    send_group(make_group(-1, 1, 1, 32767, 40, 40, 41, 42, 0, 9));
    send_group(make_group(22, 23, 24, 46, 50, 50, 50, 50, 1, 10));
    random_groups(200);

    set_config(0, 1000, 0, 1023);
    send_group(make_group(999, 1000, 1001, 32767, 10, 10, 11, 10, 0, 11));
    send_group(make_group(2000, 2000, 2000, 2000, 0, 1, 1023, 1, 1, 12));
    random_groups(150);

    set_config(1023, 0, 0, 1023);
    random_groups(150);
    set_config(5, 100, 100, 200);
    random_groups(150);
    set_config(200, 20000, 500, 1000);
    random_groups(150);
    set_config(0, 32767, 0, 1023);
    random_groups(120);
    set_config(1023, 32767, 1023, 0);
    random_groups(40);
    set_config(60, 5000, 300, 301);
    random_groups(100);

    idle_cycles(1);
    drain_results();
    if (sb.sums.size() != 0) begin
      sb.errors++;
      $display("%0t: results missing: expected %0d more, got 0", $time, sb.sums.size());
    end
    if (sb.errors == 0) begin
      $display("PASS pmt_group_coincidence_charge_sum_core");
    end else begin
      $display("FAIL pmt_group_coincidence_charge_sum_core");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL pmt_group_coincidence_charge_sum_core");
    $finish;
  end

endmodule

FILE: pmt_group_coincidence_charge_sum_core.f
rtl/pgccs_pkg.sv
rtl/pgccs_lane.sv
rtl/pgccs_merge.sv
rtl/pmt_group_coincidence_charge_sum_core.sv
tb/pmt_group_coincidence_charge_sum_core_test.sv
